[rtl/mvd_pkg.sv]
package mvd_pkg;

    localparam int NUM_BALLS = 8;
    localparam int BALL_W    = $clog2(NUM_BALLS);
    localparam int GRID_EDGE = 32;
    localparam int GRID_W    = $clog2(GRID_EDGE);
    localparam int VOX_W     = 15;
    localparam int SS_W      = 31;
    localparam int Q_W       = 32;
    localparam int FIELD_W   = 17;
    localparam int PADDR_W   = 3;

    localparam logic [FIELD_W-1:0] Q_ONE    = FIELD_W'(65536);
    localparam logic [SS_W-1:0]    SS_RESET = SS_W'(65536);
    localparam logic [7:0]         DENS_SCALE = 8'd255;

    localparam logic [BALL_W-1:0] BALL_LAST = BALL_W'(NUM_BALLS - 1);
    localparam logic [1:0]        AXIS_X    = 2'd0;
    localparam logic [1:0]        AXIS_Y    = 2'd1;
    localparam logic [1:0]        AXIS_Z    = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_SPACE_SIZE = PADDR_W'(0);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TICK   = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [2:0]          ball_index;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  vel_x;
        logic signed [31:0]  vel_y;
        logic signed [31:0]  vel_z;
        logic [30:0]         radius_in;
        logic [30:0]         frame_time;
        logic [VOX_W-1:0]    voxel_index;
    } t_item;

    typedef struct packed {
        logic [7:0]       density;
        logic [VOX_W-1:0] voxel_echo;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TMUL,
        S_TCHK,
        S_TWR,
        S_SCRD,
        S_SDIF,
        S_SMAC,
        S_SACC,
        S_SOUT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              capture;
        logic              t_mul;
        logic              t_chk;
        logic              t_wr;
        logic              s_crd;
        logic              s_dif;
        logic              s_mac;
        logic              s_acc;
        logic              s_out;
        logic [BALL_W-1:0] ball;
        logic [1:0]        axis;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[rtl/mvd_if.sv]
interface mvd_item_if;
    import mvd_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mvd_res_if;
    import mvd_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/mvd_ctrl.sv]
module mvd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mvd_pkg::t_op  i_op,
    input  mvd_pkg::t_sts i_sts,
    output logic          o_ready,
    output mvd_pkg::t_cmd o_cmd
);
    import mvd_pkg::*;

    t_state            r_state, n_state;
    logic [BALL_W-1:0] r_ball, n_ball;
    logic [1:0]        r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ball  <= '0;
            r_axis  <= AXIS_X;
        end else begin
            r_state <= n_state;
            r_ball  <= n_ball;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ball  = r_ball;
        n_axis  = r_axis;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.ball = r_ball;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_ball  = '0;
                n_axis  = AXIS_X;
                if (i_valid) begin
                    unique case (i_op)
                        OP_LOAD: o_cmd.load = 1'b1;
                        OP_TICK: begin
                            o_cmd.capture = 1'b1;
                            n_state = S_TMUL;
                        end
                        OP_SAMPLE: begin
                            o_cmd.capture = 1'b1;
                            n_state = S_SCRD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TMUL: begin
                o_cmd.t_mul = 1'b1;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                o_cmd.t_chk = 1'b1;
                n_state = S_TWR;
            end
            S_TWR: begin
                o_cmd.t_wr = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_axis = AXIS_X;
                    if (r_ball == BALL_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ball  = r_ball + 1'b1;
                        n_state = S_TMUL;
                    end
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_TMUL;
                end
            end
            S_SCRD: begin
                o_cmd.s_crd = 1'b1;
                n_state = S_SDIF;
            end
            S_SDIF: begin
                o_cmd.s_dif = 1'b1;
                n_state = S_SMAC;
            end
            S_SMAC: begin
                o_cmd.s_mac = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_axis  = AXIS_X;
                    n_state = S_SACC;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_SDIF;
                end
            end
            S_SACC: begin
                o_cmd.s_acc = 1'b1;
                if (r_ball == BALL_LAST) begin
                    n_state = S_SOUT;
                end else begin
                    n_ball  = r_ball + 1'b1;
                    n_state = S_SDIF;
                end
            end
            S_SOUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.s_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_op == OP_TICK)
        |=> (r_state == S_TMUL && r_ball == '0 && r_axis == AXIS_X))
        else $error("tick did not start at first ball");
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SOUT) |-> (r_ball == BALL_LAST && r_axis == AXIS_X))
        else $error("sample result before all balls visited");
`endif

endmodule

[rtl/mvd_dp.sv]
module mvd_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mvd_pkg::t_cmd            i_cmd,
    input  mvd_pkg::t_item           i_item,
    input  logic [mvd_pkg::SS_W-1:0] i_ss,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output mvd_pkg::t_res            o_res,
    output mvd_pkg::t_sts            o_sts
);
    import mvd_pkg::*;

    // ball table
    logic signed [31:0] r_pos [NUM_BALLS][3];
    logic signed [31:0] r_vel [NUM_BALLS][3];
    logic [SS_W-1:0]    r_rad [NUM_BALLS];

    logic [30:0]        r_ft;
    logic [VOX_W-1:0]   r_voxel;
    logic signed [63:0] r_prod;
    logic [SS_W-1:0]    r_crd [3];
    logic [23:0]        r_mag;
    logic               r_big_ax;
    logic [49:0]        r_sq;
    logic               r_big;
    logic [FIELD_W-1:0] r_field;
    logic               r_ovalid;
    t_res               r_res;

    logic signed [31:0] cur_pos, cur_vel;
    logic [SS_W-1:0]    cur_rad;
    logic signed [63:0] delta, trial, neg_prod, pos_sum;
    logic               out_rng;
    logic signed [31:0] vel_neg, pos_sat;
    logic [GRID_W+SS_W-1:0] crd_px, crd_py, crd_pz;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [47:0]        sq;
    logic [33:0]        dsum;
    logic [31:0]        add_t;
    logic [24:0]        dens_p;

    assign cur_pos = r_pos[i_cmd.ball][i_cmd.axis];
    assign cur_vel = r_vel[i_cmd.ball][i_cmd.axis];
    assign cur_rad = r_rad[i_cmd.ball];

    // motion
    assign delta   = r_prod >>> 16;
    assign trial   = 64'(cur_pos) + delta;
    assign out_rng = (trial < 0) || (trial > $signed({33'd0, i_ss}));
    assign vel_neg = (cur_vel == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -cur_vel;
    // negated velocity times ft, exact; the saturated case is one ft short
    assign neg_prod = (cur_vel == 32'sh8000_0000) ? (-r_prod - $signed({33'd0, r_ft}))
                                                  : -r_prod;
    assign pos_sum = 64'(cur_pos) + (r_prod >>> 16);
    always_comb begin
        if (pos_sum > 64'sh7FFF_FFFF) begin
            pos_sat = 32'sh7FFF_FFFF;
        end else if (pos_sum < -64'sh8000_0000) begin
            pos_sat = 32'sh8000_0000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
    end

    // sampling
    assign crd_px = r_voxel[GRID_W-1:0] * i_ss;
    assign crd_py = r_voxel[2*GRID_W-1:GRID_W] * i_ss;
    assign crd_pz = r_voxel[3*GRID_W-1:2*GRID_W] * i_ss;
    assign diff   = 33'(cur_pos) - $signed({2'b00, r_crd[i_cmd.axis]});
    assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
    assign sq     = r_mag * r_mag;
    assign dsum   = r_sq[49:16];
    assign add_t  = 32'(r_field) + (32'(cur_rad) - dsum[31:0]);
    assign dens_p = r_field * DENS_SCALE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[i_item.ball_index[BALL_W-1:0]][AXIS_X] <= i_item.pos_x;
            r_pos[i_item.ball_index[BALL_W-1:0]][AXIS_Y] <= i_item.pos_y;
            r_pos[i_item.ball_index[BALL_W-1:0]][AXIS_Z] <= i_item.pos_z;
            r_vel[i_item.ball_index[BALL_W-1:0]][AXIS_X] <= i_item.vel_x;
            r_vel[i_item.ball_index[BALL_W-1:0]][AXIS_Y] <= i_item.vel_y;
            r_vel[i_item.ball_index[BALL_W-1:0]][AXIS_Z] <= i_item.vel_z;
            r_rad[i_item.ball_index[BALL_W-1:0]]         <= i_item.radius_in;
        end
        if (i_cmd.capture) begin
            r_ft    <= i_item.frame_time;
            r_voxel <= i_item.voxel_index;
        end
        if (i_cmd.t_mul) begin
            r_prod <= cur_vel * $signed({1'b0, r_ft});
        end
        if (i_cmd.t_chk && out_rng) begin
            r_vel[i_cmd.ball][i_cmd.axis] <= vel_neg;
            r_prod <= neg_prod;
        end
        if (i_cmd.t_wr) begin
            r_pos[i_cmd.ball][i_cmd.axis] <= pos_sat;
        end
        if (i_cmd.s_crd) begin
            r_crd[AXIS_X] <= crd_px[GRID_W+SS_W-1:GRID_W];
            r_crd[AXIS_Y] <= crd_py[GRID_W+SS_W-1:GRID_W];
            r_crd[AXIS_Z] <= crd_pz[GRID_W+SS_W-1:GRID_W];
        end
        if (i_cmd.s_dif) begin
            r_mag    <= mag[23:0];
            r_big_ax <= |mag[32:24];
        end
        if (i_cmd.s_mac) begin
            r_sq  <= ((i_cmd.axis == AXIS_X) ? 50'd0 : r_sq) + 50'(sq);
            r_big <= ((i_cmd.axis == AXIS_X) ? 1'b0 : r_big) | r_big_ax;
        end
        if (i_cmd.s_out) begin
            r_res.density    <= dens_p[23:16];
            r_res.voxel_echo <= r_voxel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.s_crd) begin
                r_field <= '0;
            end else if (i_cmd.s_acc && !r_big && (dsum < 34'(cur_rad))) begin
                r_field <= (add_t > 32'(Q_ONE)) ? Q_ONE : add_t[FIELD_W-1:0];
            end
            if (i_cmd.s_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_res          = r_res;
    assign o_sts.out_busy = r_ovalid && !i_out_ready;

`ifndef SYNTHESIS
    a_field_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field <= Q_ONE)
        else $error("field sum above one");
    a_out_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.s_out |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten while stalled");
`endif

endmodule

[rtl/metaball_voxel_density.sv]
// Metaball voxel density engine.
// Input channel i_item (valid/ready) carries one transaction of three kinds:
//   load   - writes one ball of the table; no result.
//   tick   - moves every ball by velocity * frame_time / 2^16, bouncing at
//            the walls; multiply, check and write per axis and ball; no result.
//   sample - sums the field of all balls at one voxel, ball by ball and axis
//            by axis, then gives one result transaction on o_res.
// One item at a time: i_item.ready is high only while the sequencer is idle.
// o_res is a registered output: a stalled receiver holds the result; load and
// tick may run meanwhile, and a new sample waits in its last step for it.
// The APB port holds space_size (address 0), written in idle periods only,
// a rule for the user that the block itself does not enforce.
// Reset (synchronous, active low) sets space_size to 1.0 and idles the
// sequencer; the ball table is not cleared and must be loaded before use.
module metaball_voxel_density (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mvd_item_if.sink                      i_item,
    mvd_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mvd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mvd_pkg::*;

    logic [SS_W-1:0] r_ss;
    t_cmd            cmd;
    t_sts            sts;

    // space_size register: one word, read at byte address 0, written at 0 to 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= SS_RESET;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0)) begin
            r_ss <= pwdata[SS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SPACE_SIZE) ? {1'b0, r_ss} : 32'd0;

    // sequencer: owns ball/axis counters and the handshake on i_item
    mvd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_op    (i_item.data.op),
        .i_sts   (sts),
        .o_ready (i_item.ready),
        .o_cmd   (cmd)
    );

    // ball table, multipliers and accumulators, output register
    mvd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item.data),
        .i_ss        (r_ss),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_res       (o_res.data),
        .o_sts       (sts)
    );

endmodule

[tb/metaball_voxel_density_tb.sv]
module metaball_voxel_density_tb;
    import mvd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // op code 3 has no meaning: the block must drop it without a result
    localparam t_op OP_NONE = t_op'(2'd3);

    // Clock and reset
    logic i_clk;
    logic i_rst_n;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Channels and configuration port
    mvd_item_if item_ch ();
    mvd_res_if  res_ch ();

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    metaball_voxel_density dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the ball table and of space_size
    int              ball_px [NUM_BALLS];
    int              ball_py [NUM_BALLS];
    int              ball_pz [NUM_BALLS];
    int              ball_vx [NUM_BALLS];
    int              ball_vy [NUM_BALLS];
    int              ball_vz [NUM_BALLS];
    logic [30:0]     ball_r  [NUM_BALLS];
    logic [SS_W-1:0] cube_edge;

    t_item item_pending[$];  // transactions waiting to be driven
    t_res  density_due[$];   // densities the block still owes us

    int  error_count;
    bit  calm;       // no random idling on either side
    bit  hold_req;   // ask the receiver for one long hold-off
    int  hold_left;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // One axis of a tick: bounce first if the trial position leaves the cube,
    // then step with saturation. Step is floor((vel*ft) / 2^16).
    function automatic void step_axis(input int p, input int v, input logic [30:0] ft,
                                      output int np, output int nv);
        longint delta;
        longint trial;
        longint sum;
        delta = (longint'(v) * longint'(ft)) >>> 16;
        trial = longint'(p) + delta;
        nv = v;
        if (trial < 0 || trial > longint'(cube_edge)) begin
            nv = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
            delta = (longint'(nv) * longint'(ft)) >>> 16;
        end
        sum = longint'(p) + delta;
        if (sum > 64'sh7fff_ffff)
            np = 32'sh7fff_ffff;
        else if (sum < -64'sh8000_0000)
            np = 32'sh8000_0000;
        else
            np = int'(sum);
    endfunction

    function automatic void advance_balls(input logic [30:0] ft);
        for (int b = 0; b < NUM_BALLS; b++) begin
            step_axis(ball_px[b], ball_vx[b], ft, ball_px[b], ball_vx[b]);
            step_axis(ball_py[b], ball_vy[b], ft, ball_py[b], ball_vy[b]);
            step_axis(ball_pz[b], ball_vz[b], ft, ball_pz[b], ball_vz[b]);
        end
    endfunction

    function automatic logic [63:0] dist_sq(input int p, input longint c);
        longint      d;
        logic [63:0] m;
        d = longint'(p) - c;
        m = (d < 0) ? 64'(-d) : 64'(d);
        return m * m;
    endfunction

    function automatic logic [7:0] voxel_density(input logic [VOX_W-1:0] vi);
        longint      cx;
        longint      cy;
        longint      cz;
        logic [65:0] s;
        logic [49:0] d;
        logic [31:0] field;
        cx = (longint'(vi[4:0])   * longint'(cube_edge)) / GRID_EDGE;
        cy = (longint'(vi[9:5])   * longint'(cube_edge)) / GRID_EDGE;
        cz = (longint'(vi[14:10]) * longint'(cube_edge)) / GRID_EDGE;
        field = '0;
        for (int b = 0; b < NUM_BALLS; b++) begin
            s = 66'(dist_sq(ball_px[b], cx)) + 66'(dist_sq(ball_py[b], cy))
              + 66'(dist_sq(ball_pz[b], cz));
            d = 50'(s >> 16);
            if (d < 50'(ball_r[b])) begin
                field = field + 32'(50'(ball_r[b]) - d);
                if (field > 32'd65536)
                    field = 32'd65536;
            end
        end
        return 8'((field * 32'd255) >> 16);
    endfunction

    function automatic void predict_item(input t_item it);
        t_res r;
        case (it.op)
            OP_LOAD: begin
                ball_px[it.ball_index] = it.pos_x;
                ball_py[it.ball_index] = it.pos_y;
                ball_pz[it.ball_index] = it.pos_z;
                ball_vx[it.ball_index] = it.vel_x;
                ball_vy[it.ball_index] = it.vel_y;
                ball_vz[it.ball_index] = it.vel_z;
                ball_r[it.ball_index]  = it.radius_in;
            end
            OP_TICK: begin
                advance_balls(it.frame_time);
            end
            OP_SAMPLE: begin
                r.density    = voxel_density(it.voxel_index);
                r.voxel_echo = it.voxel_index;
                density_due.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: takes the next pending transaction, after random idling unless calm, when the slot is free
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                predict_item(item_ch.data);
            if (!item_ch.valid || item_ch.ready) begin
                if (item_pending.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= item_pending.pop_front();
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req && hold_left == 0) begin
            hold_left    <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_left == 1)
                hold_left <= -1;  // hold-off done, never again
            res_ch.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // Monitor: every accepted result against the oldest expected density and voxel
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (density_due.size() == 0) begin
                $display("%0t: unexpected result density=%0d voxel=%0d", $realtime,
                         res_ch.data.density, res_ch.data.voxel_echo);
                error_count++;
            end else begin
                t_res want;
                want = density_due.pop_front();
                if (res_ch.data.density !== want.density) begin
                    $display("%0t: density mismatch voxel %0d: expected %0d, actual %0d",
                             $realtime, want.voxel_echo, want.density, res_ch.data.density);
                    error_count++;
                end
                if (res_ch.data.voxel_echo !== want.voxel_echo) begin
                    $display("%0t: voxel_echo mismatch: expected %0d, actual %0d",
                             $realtime, want.voxel_echo, res_ch.data.voxel_echo);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_item load_item(input logic [2:0] b, input int px, input int py,
                                        input int pz, input int vx, input int vy,
                                        input int vz, input logic [30:0] rad);
        t_item it;
        it            = '0;
        it.op         = OP_LOAD;
        it.ball_index = b;
        it.pos_x      = px;
        it.pos_y      = py;
        it.pos_z      = pz;
        it.vel_x      = vx;
        it.vel_y      = vy;
        it.vel_z      = vz;
        it.radius_in  = rad;
        return it;
    endfunction

    function automatic t_item tick_item(input logic [30:0] ft);
        t_item it;
        it            = '0;
        it.op         = OP_TICK;
        it.frame_time = ft;
        return it;
    endfunction

    function automatic t_item sample_item(input logic [VOX_W-1:0] vi);
        t_item it;
        it             = '0;
        it.op          = OP_SAMPLE;
        it.voxel_index = vi;
        return it;
    endfunction

    // Random value below a randomly chosen power of two, so small magnitudes show up
    function automatic logic [31:0] ranged(input int max_bits);
        return 32'($urandom & ((64'd1 << $urandom_range(max_bits, 1)) - 1));
    endfunction

    // A ball inside the cube with modest speed and a radius in reach of the grid
    function automatic t_item sane_ball();
        logic [30:0] edge_len;
        edge_len = cube_edge;
        return load_item(3'($urandom_range(NUM_BALLS - 1)),
                         int'($urandom_range(edge_len)), int'($urandom_range(edge_len)),
                         int'($urandom_range(edge_len)),
                         $signed(ranged(20)) - (1 <<< 19), $signed(ranged(20)) - (1 <<< 19),
                         $signed(ranged(20)) - (1 <<< 19), 31'(ranged(31)));
    endfunction

    function automatic t_item random_item();
        t_item        it;
        int           pick;
        logic [319:0] noise;
        pick = $urandom_range(99);
        if (pick < 25) begin
            it = sane_ball();
        end else if (pick < 30) begin
            // raw noise in every field, op forced to a load
            noise         = {$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom};
            it            = noise[$bits(t_item)-1:0];
            it.op         = OP_LOAD;
        end else if (pick < 45) begin
            it = tick_item(($urandom_range(9) == 0) ? 31'($urandom) : 31'(ranged(17)));
        end else begin
            it = sample_item(15'($urandom));
        end
        return it;
    endfunction

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SPACE_SIZE)
            cube_edge = value[SS_W-1:0];
    endtask

    // Everything sent and answered, then room for a tick still in flight
    task automatic drain();
        while (item_pending.size() > 0 || item_ch.valid || density_due.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        t_item it;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        error_count   = 0;
        cube_edge     = SS_RESET;
        for (int b = 0; b < NUM_BALLS; b++) begin
            ball_px[b] = 0; ball_py[b] = 0; ball_pz[b] = 0;
            ball_vx[b] = 0; ball_vy[b] = 0; ball_vz[b] = 0;
            ball_r[b]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset space_size (1.0). Load every ball before any tick or
        // sample reads the table; include position/velocity extremes.
        item_pending.push_back(load_item(3'd0, 32'sh8000_0000, 32'sh7fff_ffff, 0,
                                         32'sh8000_0000, 32'sh7fff_ffff, 0, 31'h7fff_ffff));
        item_pending.push_back(load_item(3'd1, 32'sh7fff_ffff, 32'sh8000_0000, 65536,
                                         32'sh7fff_ffff, 32'sh8000_0000, -1, 31'd0));
        item_pending.push_back(load_item(3'd2, 0, 0, 0, 0, 0, 0, 31'd1000));
        item_pending.push_back(load_item(3'd3, 65536, 65536, 65536, 1, -1, 0, 31'd65536));
        item_pending.push_back(load_item(3'd4, 32768, 32768, 32768, 4096, -4096, 0, 31'd8192));
        item_pending.push_back(load_item(3'd5, -5, 70000, 1, 0, 0, 0, 31'd0));
        item_pending.push_back(load_item(3'd6, 2048, 0, 63488, 0, 0, 0, 31'd0));
        item_pending.push_back(load_item(3'd7, 0, 65536, 0, -65536, 65536, 0, 31'd0));
        // both corners of the cube with the full table
        item_pending.push_back(sample_item(15'd0));
        item_pending.push_back(sample_item(15'h7fff));
        // kill ball 0, then see the small ones
        item_pending.push_back(load_item(3'd0, 0, 0, 0, 32'sh8000_0000, 0, 0, 31'd0));
        item_pending.push_back(sample_item(15'd0));
        item_pending.push_back(sample_item(15'd16 | (15'd16 << 5) | (15'd16 << 10)));
        item_pending.push_back(tick_item(31'd0));
        item_pending.push_back(tick_item(31'd65536));   // bounces, INT_MIN negation
        item_pending.push_back(sample_item(15'd31));
        it    = tick_item(31'd0);
        it.op = OP_NONE;
        item_pending.push_back(it);                     // ignored op
        item_pending.push_back(tick_item(31'h7fff_ffff)); // saturating move
        item_pending.push_back(sample_item(15'h4210));
        drain();

        // Random phases across several cube sizes, extremes included
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: apb_write(ADDR_SPACE_SIZE, 32'h7fff_ffff);
                1: apb_write(ADDR_SPACE_SIZE, 32'd1);
                2: apb_write(ADDR_SPACE_SIZE, 32'd65536 * 4);
                default: apb_write(ADDR_SPACE_SIZE, 32'($urandom_range(32'h7fff_ffff, 1)));
            endcase
            // fresh well-formed table for this cube size
            for (int b = 0; b < NUM_BALLS; b++) begin
                it            = sane_ball();
                it.ball_index = 3'(b);
                item_pending.push_back(it);
            end
            calm = (phase == 2);  // one phase with no idling at all
            for (int n = 0; n < 120; n++) begin
                item_pending.push_back(random_item());
                if (phase == 1 && n == 20)
                    hold_req = 1'b1;  // receiver stalls while items keep coming
                while (item_pending.size() > 4)
                    @(posedge i_clk);
            end
            calm = 1'b0;
            drain();  // sender waits until every density has come back
        end

        drain();
        if (error_count == 0)
            $display("metaball_voxel_density_tb: done, clean");
        else
            $display("metaball_voxel_density_tb: done, errors");
        $finish;
    end

    // Run limit
    initial begin
        #5ms;
        $display("metaball_voxel_density_tb: done, errors");
        $finish;
    end

endmodule
